/* rtl/core/shtli_pkg.sv */
package shtli_pkg;

  // Item field widths
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned NAME_BYTES = 8;
  localparam int unsigned SUM_W    = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned OUT_W    = 16;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_FOUND   = 2'd0;
  localparam status_t ST_CREATED = 2'd1;
  localparam status_t ST_MISSING = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

endpackage

/* rtl/core/shtli_ram.sv */
module shtli_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/shtli_hash.sv */
module shtli_hash #(
  parameter int unsigned NAME_CHARS = 8
) (
  input  logic [shtli_pkg::NAME_W-1:0] name_i,
  output logic [shtli_pkg::NAME_W-1:0] name_o,
  output logic [shtli_pkg::SUM_W-1:0]  sum_o
);

  // Drop bytes at or above index NAME_CHARS, then add up the rest
  always_comb begin
    logic [shtli_pkg::SUM_W-1:0] acc;
    acc    = '0;
    name_o = '0;
    for (int unsigned i = 0; i < shtli_pkg::NAME_BYTES; i++) begin
      if (i < NAME_CHARS) begin
        name_o[8*i +: 8] = name_i[8*i +: 8];
        acc = acc + shtli_pkg::SUM_W'(name_i[8*i +: 8]);
      end
    end
    sum_o = acc;
  end

endmodule

/* rtl/core/symbol_hash_table_lookup_insert.sv */
// Symbol table engine: a chained hash table keyed by names of up to eight
// packed bytes (first character in the low byte, null filled). Each input
// word carries a name on tdata and a create flag on tuser; each yields one
// output word with a status (found, created, not found, table full) and the
// entry index (low 8 bits; zero for not found and full). The hash is the sum
// of the name bytes and its low BUCKET_BITS bits pick a bucket; the chain is
// walked from the bucket head, one entry memory read per visited entry, and
// new entries come from a bump counter and are linked at the chain head.
// After a word is taken it passes the hash state (bucket head read), the head
// state, one walk step per chain entry visited, a miss step when the lookup
// misses, and the output state; the entry memory read port sets the walk pace.
// The next word can be taken once the result is loaded, so an item holds the
// block until then, longer when the output register is still held by the sink.
// The block works on one word at a time; a finished result waits in the
// output register while the next name is taken in. Bucket heads are empty
// after reset with no clearing pass; entries are never freed.
module symbol_hash_table_lookup_insert #(
  parameter int unsigned NAME_CHARS  = 8,
  parameter int unsigned BUCKET_BITS = 6,
  parameter int unsigned ENTRY_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // name[63:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  // create[0]
  input  logic        s_axis_tuser,
  // status[1:0], entry_index[9:2], zero fill [15:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata
);

  localparam int unsigned BUCKETS = 1 << BUCKET_BITS;
  localparam int unsigned IDX_W   = $clog2(ENTRY_COUNT);
  localparam int unsigned CNT_W   = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned NAME_W  = shtli_pkg::NAME_W;
  localparam int unsigned SUM_W   = shtli_pkg::SUM_W;
  localparam int unsigned ENT_W   = 1 + IDX_W + SUM_W + NAME_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRY_COUNT);
  localparam logic [CNT_W:0]   STEP_LIM = (CNT_W+1)'(ENTRY_COUNT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_HEAD,
    S_WALK,
    S_MISS,
    S_OUT
  } state_e;

  state_e                  state_q, state_d;
  logic [NAME_W-1:0]       name_q, name_d;
  logic                    create_q, create_d;
  logic [SUM_W-1:0]        sum_q, sum_d;
  logic [IDX_W-1:0]        cur_q, cur_d;
  logic [CNT_W-1:0]        steps_q, steps_d;
  logic [CNT_W-1:0]        used_q, used_d;
  logic [IDX_W-1:0]        head_idx_q, head_idx_d;
  logic                    head_have_q, head_have_d;
  logic [BUCKETS-1:0]      head_vld_q, head_vld_d;
  shtli_pkg::status_t      res_st_q, res_st_d;
  logic [IDX_W-1:0]        res_idx_q, res_idx_d;
  logic                    out_valid_q, out_valid_d;
  logic [15:0]             out_data_q, out_data_d;

  logic [NAME_W-1:0]       name_masked;
  logic [SUM_W-1:0]        name_sum;
  logic [BUCKET_BITS-1:0]  bucket;

  logic                    head_we, head_re;
  logic [BUCKET_BITS-1:0]  head_raddr;
  logic [IDX_W-1:0]        head_wdata, head_rdata;

  logic                    ent_we, ent_re;
  logic [IDX_W-1:0]        ent_waddr, ent_raddr;
  logic [ENT_W-1:0]        ent_wdata, ent_rdata;
  logic [NAME_W-1:0]       ent_name;
  logic [SUM_W-1:0]        ent_sum;
  logic [IDX_W-1:0]        ent_link;
  logic                    ent_link_vld;

  logic [IDX_W+7:0]        res_idx_ext;

  shtli_hash #(
    .NAME_CHARS(NAME_CHARS)
  ) u_hash (
    .name_i (s_axis_tdata),
    .name_o (name_masked),
    .sum_o  (name_sum)
  );

  // Bucket head indexes; their valid bits live in head_vld_q
  shtli_ram #(
    .WIDTH(IDX_W),
    .DEPTH(BUCKETS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (bucket),
    .wdata_i (head_wdata),
    .re_i    (head_re),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  // Entry store: {link valid, link index, sum, name}
  shtli_ram #(
    .WIDTH(ENT_W),
    .DEPTH(ENTRY_COUNT)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign bucket = sum_q[BUCKET_BITS-1:0];
  assign {ent_link_vld, ent_link, ent_sum, ent_name} = ent_rdata;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Report only the low byte of the entry index
  assign res_idx_ext = {8'd0, res_idx_q};

  always_comb begin
    state_d     = state_q;
    name_d      = name_q;
    create_d    = create_q;
    sum_d       = sum_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    used_d      = used_q;
    head_idx_d  = head_idx_q;
    head_have_d = head_have_q;
    head_vld_d  = head_vld_q;
    res_st_d    = res_st_q;
    res_idx_d   = res_idx_q;

    head_we    = 1'b0;
    head_re    = 1'b0;
    head_raddr = sum_q[BUCKET_BITS-1:0];
    head_wdata = used_q[IDX_W-1:0];
    ent_we     = 1'b0;
    ent_re     = 1'b0;
    ent_raddr  = head_rdata;
    ent_waddr  = used_q[IDX_W-1:0];
    ent_wdata  = {head_have_q, head_idx_q, sum_q, name_q};

    // Drain the output register when the sink takes the word
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          name_d   = name_masked;
          sum_d    = name_sum;
          create_d = s_axis_tuser;
          state_d  = S_HASH;
        end
      end
      S_HASH: begin
        // Fetch the bucket head
        head_re    = 1'b1;
        head_raddr = sum_q[BUCKET_BITS-1:0];
        state_d    = S_HEAD;
      end
      S_HEAD: begin
        head_idx_d  = head_rdata;
        head_have_d = head_vld_q[bucket];
        if (head_vld_q[bucket]) begin
          ent_re    = 1'b1;
          ent_raddr = head_rdata;
          cur_d     = head_rdata;
          steps_d   = '0;
          state_d   = S_WALK;
        end else begin
          state_d = S_MISS;
        end
      end
      S_WALK: begin
        if (ent_sum == sum_q && ent_name == name_q) begin
          res_st_d  = shtli_pkg::ST_FOUND;
          res_idx_d = cur_q;
          state_d   = S_OUT;
        end else if (ent_link_vld && (({1'b0, steps_q} + 1'b1) < STEP_LIM)) begin
          // Advance to the next chain entry
          ent_re    = 1'b1;
          ent_raddr = ent_link;
          cur_d     = ent_link;
          steps_d   = steps_q + 1'b1;
        end else begin
          state_d = S_MISS;
        end
      end
      S_MISS: begin
        res_idx_d = '0;
        if (!create_q) begin
          res_st_d = shtli_pkg::ST_MISSING;
        end else if (used_q == FULL_CNT) begin
          res_st_d = shtli_pkg::ST_FULL;
        end else begin
          // Fill the next free entry and push it on the chain head
          ent_we             = 1'b1;
          head_we            = 1'b1;
          head_vld_d[bucket] = 1'b1;
          used_d             = used_q + 1'b1;
          res_st_d           = shtli_pkg::ST_CREATED;
          res_idx_d          = used_q[IDX_W-1:0];
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {6'd0, res_idx_ext[7:0], res_st_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      head_vld_q  <= '0;
      out_valid_q <= 1'b0;
      steps_q     <= '0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      head_vld_q  <= head_vld_d;
      out_valid_q <= out_valid_d;
      steps_q     <= steps_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    name_q      <= name_d;
    create_q    <= create_d;
    sum_q       <= sum_d;
    cur_q       <= cur_d;
    head_idx_q  <= head_idx_d;
    head_have_q <= head_have_d;
    res_st_q    <= res_st_d;
    res_idx_q   <= res_idx_d;
    out_data_q  <= out_data_d;
  end

endmodule

/* test/symtab_checker.sv */
`timescale 1ns / 1ps

module symtab_checker
  import shtli_pkg::*;
#(
  parameter int unsigned NAME_CHARS  = 8,
  parameter int unsigned BUCKET_BITS = 6,
  parameter int unsigned ENTRY_COUNT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [63:0] s_tdata_i,    // name[63:0]
  input  logic        s_tuser_i,    // create[0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,    // status[1:0], entry_index[9:2], zero fill
  output int          mismatches_o,
  output int          outstanding_o,
  output int          found_o,
  output int          created_o,
  output int          missing_o,
  output int          full_o
);

  localparam int unsigned BUCKETS = 1 << BUCKET_BITS;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] index;
  } lookup_reply_t;

  // Shadow copy of the table
  bit                head_ok  [BUCKETS];
  int unsigned       head_at  [BUCKETS];
  logic [NAME_W-1:0] slot_name[ENTRY_COUNT];
  logic [SUM_W-1:0]  slot_sum [ENTRY_COUNT];
  bit                link_ok  [ENTRY_COUNT];
  int unsigned       link_at  [ENTRY_COUNT];
  int unsigned       slots_used;
  lookup_reply_t     expected_lookups[$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    found_o       = 0;
    created_o     = 0;
    missing_o     = 0;
    full_o        = 0;
    slots_used    = 0;
  end

  // Look the name up in the shadow table, insert it on a miss with create,
  // and queue the word the block owes for it.
  task automatic resolve_symbol(input logic [NAME_W-1:0] raw, input logic create);
    logic [NAME_W-1:0] nm;
    logic [SUM_W-1:0]  sum;
    int unsigned       bucket;
    int unsigned       cur;
    int unsigned       steps;
    bit                have;
    bit                hit;
    lookup_reply_t     reply;
    nm  = '0;
    sum = '0;
    // bytes at or above NAME_CHARS take no part anywhere
    for (int b = 0; b < NAME_CHARS && b < NAME_BYTES; b++) begin
      nm[8*b +: 8] = raw[8*b +: 8];
      sum += raw[8*b +: 8];
    end
    bucket = sum % BUCKETS;
    have   = head_ok[bucket];
    cur    = head_at[bucket];
    steps  = 0;
    hit    = 1'b0;
    while (have && steps < ENTRY_COUNT && !hit) begin
      if (slot_sum[cur] == sum && slot_name[cur] == nm) begin
        hit = 1'b1;
      end else begin
        have = link_ok[cur];
        cur  = link_at[cur];
        steps++;
      end
    end
    if (hit) begin
      reply.status = ST_FOUND;
      reply.index  = cur[INDEX_W-1:0];
      found_o++;
    end else if (!create) begin
      reply.status = ST_MISSING;
      reply.index  = '0;
      missing_o++;
    end else if (slots_used >= ENTRY_COUNT) begin
      reply.status = ST_FULL;
      reply.index  = '0;
      full_o++;
    end else begin
      // take the next free slot and push it on the chain head
      cur             = slots_used;
      slots_used++;
      slot_name[cur]  = nm;
      slot_sum[cur]   = sum;
      link_ok[cur]    = head_ok[bucket];
      link_at[cur]    = head_at[bucket];
      head_ok[bucket] = 1'b1;
      head_at[bucket] = cur;
      reply.status    = ST_CREATED;
      reply.index     = cur[INDEX_W-1:0];
      created_o++;
    end
    expected_lookups.push_back(reply);
  endtask

  always @(posedge clk_i) begin
    lookup_reply_t got;
    lookup_reply_t want;
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) head_ok[b] = 1'b0;
      slots_used = 0;
      expected_lookups.delete();
    end else begin
      // compare first: a word leaving now cannot belong to a name taken now
      if (m_tvalid_i && m_tready_i) begin
        got.status = m_tdata_i[STATUS_W-1:0];
        got.index  = m_tdata_i[STATUS_W +: INDEX_W];
        if (expected_lookups.size() == 0) begin
          mismatches_o++;
          $display("%0t: output word %h with none expected", $time, m_tdata_i);
        end else begin
          want = expected_lookups.pop_front();
          if (got.status !== want.status) begin
            mismatches_o++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          end
          if (got.index !== want.index) begin
            mismatches_o++;
            $display("%0t: entry_index expected %0d, got %0d", $time, want.index, got.index);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) resolve_symbol(s_tdata_i, s_tuser_i);
    end
    outstanding_o = expected_lookups.size();
  end

endmodule

/* test/symbol_hash_table_lookup_insert_tb.sv */
`timescale 1ns / 1ps

module symbol_hash_table_lookup_insert_tb;
  import shtli_pkg::*;

  localparam int unsigned ENTRY_COUNT  = 256;
  localparam int          RANDOM_WORDS = 550;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          DRAIN_CYCLES = 40;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;    // name[63:0]
  logic        s_axis_tuser  = 1'b0;  // create[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // status[1:0], entry_index[9:2], zero fill

  int mismatches;
  int outstanding;
  int n_found;
  int n_created;
  int n_missing;
  int n_full;

  // no random gaps on either side while set
  bit calm         = 1'b0;
  int sink_hold    = 0;
  int quiet_cycles = 0;

  // names the table holds, as far as the stimulus knows
  bit          name_stored[logic [63:0]];
  logic [63:0] stored_names[$];

  always #4 clk_i = ~clk_i;

  symbol_hash_table_lookup_insert uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  symtab_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .found_o       (n_found),
    .created_o     (n_created),
    .missing_o     (n_missing),
    .full_o        (n_full)
  );

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pack a string into a name, first character in the low byte.
  function automatic logic [63:0] pack_name(input string s);
    logic [63:0] nm;
    nm = '0;
    for (int b = 0; b < s.len() && b < 8; b++) nm[8*b +: 8] = s[b];
    return nm;
  endfunction

  // Draw a name the table does not hold yet: mostly null-filled strings of
  // random length, sometimes a raw random 64-bit pattern that may hold nulls.
  function automatic logic [63:0] fresh_name();
    logic [63:0] nm;
    int          len;
    do begin
      nm = '0;
      if ($urandom_range(0, 9) == 0) begin
        nm = {$urandom, $urandom};
      end else begin
        len = $urandom_range(1, 8);
        for (int b = 0; b < len; b++) nm[8*b +: 8] = 8'($urandom_range(1, 255));
      end
    end while (name_stored.exists(nm));
    return nm;
  endfunction

  // Offer one word and hold it until the block takes it.
  task automatic send_symbol(input logic [63:0] nm, input bit create);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= nm;
    s_axis_tuser  <= create;
    do @(posedge clk_i); while (!s_axis_tready);
    if (create && !name_stored.exists(nm) && stored_names.size() < ENTRY_COUNT) begin
      name_stored[nm] = 1'b1;
      stored_names.push_back(nm);
    end
  endtask

  // Drop valid so the last word is not taken twice.
  task automatic pause_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Receiver: ready for a cycle, then stall for a random gap that may be zero.
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold = pick_gap();
    end
  end

  // Watchdog: end the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog: no word moved in %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [63:0] nm;
    logic [7:0]  tmp;
    bit          create;
    int          pick;
    int          i;
    int          j;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty name, all-ones name (largest sum), equal sums with
    // different names, embedded null, top-byte-only difference, same bucket
    // with different sums, lookups that miss.
    send_symbol(64'h0, 1'b0);
    send_symbol(64'h0, 1'b1);
    send_symbol(64'h0, 1'b0);
    send_symbol(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_symbol(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_symbol(pack_name("ab"), 1'b1);
    send_symbol(pack_name("ba"), 1'b1);
    send_symbol(pack_name("ab"), 1'b1);
    send_symbol(pack_name("ba"), 1'b0);
    send_symbol(64'h0000_0000_0062_0061, 1'b0);
    send_symbol(pack_name("abcdefgh"), 1'b1);
    send_symbol(pack_name("abcdefgi"), 1'b0);
    send_symbol(64'h8000_0000_0000_0000, 1'b1);
    send_symbol(64'h01, 1'b1);
    send_symbol(64'h41, 1'b1);
    send_symbol(64'h41, 1'b0);
    send_symbol(64'h01, 1'b0);
    send_symbol(pack_name("zz"), 1'b0);
    send_symbol(64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    send_symbol(pack_name("A"), 1'b0);

    // let the block drain completely before the random part
    pause_sender();
    wait (outstanding == 0);

    // Random: inserts fill the table part way through, so later creates of
    // new names hit the full case while lookups keep walking long chains.
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      calm = ((k / 50) % 4) == 3;
      pick = $urandom_range(0, 99);
      if (stored_names.size() == 0 || pick < 50) begin
        nm     = fresh_name();
        create = 1'b1;
      end else if (pick < 72) begin
        nm     = stored_names[$urandom_range(0, stored_names.size() - 1)];
        create = 1'($urandom_range(0, 1));
      end else if (pick < 82) begin
        nm     = fresh_name();
        create = 1'b0;
      end else begin
        // swap two bytes: same sum, usually a different name
        nm  = stored_names[$urandom_range(0, stored_names.size() - 1)];
        i   = $urandom_range(0, 7);
        j   = $urandom_range(0, 7);
        tmp = nm[8*i +: 8];
        nm[8*i +: 8] = nm[8*j +: 8];
        nm[8*j +: 8] = tmp;
        create = 1'($urandom_range(0, 1));
      end
      send_symbol(nm, create);
    end
    calm = 1'b0;

    pause_sender();
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d lookups: %0d found, %0d created, %0d not found, %0d table full",
             n_found + n_created + n_missing + n_full, n_found, n_created, n_missing, n_full);
    $display("Both sides stalled at random with quiet stretches; one full drain mid-run");
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/shtli_pkg.sv
rtl/core/shtli_ram.sv
rtl/core/shtli_hash.sv
rtl/core/symbol_hash_table_lookup_insert.sv
test/symtab_checker.sv
test/symbol_hash_table_lookup_insert_tb.sv
